[src/ibt_pkg.sv]
// Shared types and sizes for the interval booking table.
`default_nettype none

package ibt_pkg;

    localparam int MAX_BOOKINGS = 64;
    localparam int TIME_BITS    = 32;

    typedef logic [TIME_BITS-1:0] t_time;

    // One stored booking; live is set when the interval is not empty.
    typedef struct packed {
        logic  valid;
        logic  live;
        t_time tm_start;
        t_time tm_end;
    } t_entry;

    // Control from the top level to the chain.
    typedef struct packed {
        logic  shift;
        logic  req_live;
        t_time req_start;
        t_time req_end;
    } t_chain_ctl;

    // Status from the chain back to the top level.
    typedef struct packed {
        logic hit;
        logic full;
    } t_chain_stat;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EVAL = 2'b10
    } t_state;

endpackage

`default_nettype wire

[src/interval_booking_table.sv]
// Interval booking table: rejects requests that overlap a stored booking or find the table full, stores the rest.
//
// Each item is a half-open interval [start, end) checked against up to 64 stored
// bookings held in a chain of cells, one booking per cell. The request is first
// registered; then every cell compares it with its booking, the hits are
// OR-reduced and, if there is no overlap and the last cell is still free, the
// chain shifts to take the new booking at its head when the output register can
// take the result. The next request must see that insert, so one item is handled
// at a time and a new item is not accepted before the previous one is finished.
// The result sits in an output register, so a new item can be accepted while the
// previous result waits. Reset empties the table.
`default_nettype none

module interval_booking_table
    import ibt_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire t_time i_interval_start,
    input  wire t_time i_interval_end,
    output logic       o_valid,
    input  wire logic  i_ready,
    output logic       o_accepted,
    output logic       o_rejected_full
);

    t_state      r_state, n_state;
    t_time       r_req_start;
    t_time       r_req_end;
    logic        r_out_valid, n_out_valid;
    logic        r_out_accepted;
    logic        r_out_full;
    t_chain_ctl  w_ctl;
    t_chain_stat w_stat;
    logic        w_accept_in;
    logic        w_commit;
    logic        w_insert;

    assign o_ready     = (r_state == S_IDLE);
    assign w_accept_in = i_valid && o_ready;
    assign w_commit    = (r_state == S_EVAL) && (!r_out_valid || i_ready);
    assign w_insert    = w_commit && !w_stat.hit && !w_stat.full;

    assign w_ctl = '{shift: w_insert, req_live: (r_req_start < r_req_end),
                     req_start: r_req_start, req_end: r_req_end};

    ibt_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .o_stat  (w_stat)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept_in) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (w_commit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_commit) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept_in) begin
            r_req_start <= i_interval_start;
            r_req_end   <= i_interval_end;
        end
        if (w_commit) begin
            r_out_accepted <= !w_stat.hit && !w_stat.full;
            r_out_full     <= !w_stat.hit && w_stat.full;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_accepted      = r_out_accepted;
    assign o_rejected_full = r_out_full;

    a_one_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_accepted && o_rejected_full))
        else $error("result both accepted and rejected for a full table");

    a_insert_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_insert |-> (!w_stat.hit && !w_stat.full && r_state == S_EVAL))
        else $error("insert with overlap, full table or no pending item");

    a_commit_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |=> (o_valid && r_state == S_IDLE))
        else $error("finished item did not produce a result");

    a_accept_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept_in |=> (r_state == S_EVAL))
        else $error("accepted item not under evaluation");

endmodule

`default_nettype wire

[src/ibt_cell.sv]
// One cell of the booking chain: holds one interval and checks it against the request.
`default_nettype none

module ibt_cell
    import ibt_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_chain_ctl i_ctl,
    input  wire t_entry     i_prev,
    output t_entry          o_entry,
    output logic            o_hit
);

    logic   r_valid;
    logic   r_live;
    t_time  r_start;
    t_time  r_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.shift) begin
            r_valid <= i_prev.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_live  <= i_prev.live;
            r_start <= i_prev.tm_start;
            r_end   <= i_prev.tm_end;
        end
    end

    // max(starts) < min(ends) is the same as each start lying below each end.
    assign o_hit = r_valid && r_live && i_ctl.req_live
                   && (r_start < i_ctl.req_end) && (i_ctl.req_start < r_end);

    assign o_entry = '{valid: r_valid, live: r_live, tm_start: r_start, tm_end: r_end};

endmodule

`default_nettype wire

[src/ibt_chain.sv]
// Row of booking cells with the overlap reduction and the full flag.
`default_nettype none

module ibt_chain
    import ibt_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_chain_ctl i_ctl,
    output t_chain_stat     o_stat
);

    t_entry                  w_entry [MAX_BOOKINGS];
    logic [MAX_BOOKINGS-1:0] w_hit;
    logic [MAX_BOOKINGS-1:0] w_valid;
    t_entry                  w_new;

    assign w_new = '{valid: 1'b1, live: i_ctl.req_live,
                     tm_start: i_ctl.req_start, tm_end: i_ctl.req_end};

    // A new booking enters at cell 0 and every stored one moves one cell on.
    genvar g;
    generate
        for (g = 0; g < MAX_BOOKINGS; g++) begin : g_cell
            if (g == 0) begin : g_head
                ibt_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_ctl   (i_ctl),
                    .i_prev  (w_new),
                    .o_entry (w_entry[g]),
                    .o_hit   (w_hit[g])
                );
            end else begin : g_body
                ibt_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_ctl   (i_ctl),
                    .i_prev  (w_entry[g-1]),
                    .o_entry (w_entry[g]),
                    .o_hit   (w_hit[g])
                );
            end
            assign w_valid[g] = w_entry[g].valid;
        end
    endgenerate

    assign o_stat.hit  = |w_hit;
    assign o_stat.full = w_entry[MAX_BOOKINGS-1].valid;

    // Occupied cells always form an unbroken run starting at cell 0.
    a_valid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid + {{(MAX_BOOKINGS-1){1'b0}}, 1'b1}) & w_valid) == '0)
        else $error("occupied cells are not contiguous");

    a_shift_fills_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.shift |=> w_valid[0])
        else $error("insert did not fill the head cell");

endmodule

`default_nettype wire

[verif/testbench.sv]
// Self-checking testbench for the interval booking table.
`timescale 1ns / 1ps

module testbench;
    import ibt_pkg::*;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int RANDOM_ITEMS  = 1150;
    localparam int MAX_PAUSE     = 16;
    localparam int DRAIN_CYCLES  = 20;

    typedef struct {
        t_time s;
        t_time e;
    } t_request;

    typedef struct packed {
        logic accepted;
        logic rejected_full;
    } t_verdict;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_valid = 1'b0;
    logic  o_ready;
    t_time i_interval_start = '0;
    t_time i_interval_end = '0;
    logic  o_valid;
    logic  i_ready = 1'b0;
    logic  o_accepted;
    logic  o_rejected_full;

    interval_booking_table uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_interval_start (i_interval_start),
        .i_interval_end   (i_interval_end),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_accepted       (o_accepted),
        .o_rejected_full  (o_rejected_full)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Our own copy of the table contents.
    t_time       booked_lo [MAX_BOOKINGS];
    t_time       booked_hi [MAX_BOOKINGS];
    int unsigned booked_n = 0;

    t_request pending_requests[$];
    t_request asked[$];
    t_verdict verdicts_due[$];

    int unsigned err_count = 0;
    int unsigned n_stored = 0;
    int unsigned n_overlap = 0;
    int unsigned n_full = 0;
    int unsigned cycle_count = 0;

    // Handshake flags passed from the sampling edge to the driving edge.
    bit          req_taken = 1'b0;
    bit          res_taken = 1'b0;
    bit          drv_busy = 1'b0;
    bit          drv_quiet = 1'b0;
    int unsigned drv_pause = 0;
    int unsigned drv_sent = 0;
    t_request    drv_item;
    bit          rcv_quiet = 1'b0;
    int unsigned rcv_stall = 0;
    int unsigned rcv_done = 0;

    task automatic flag_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        err_count++;
    endtask

    // Checks a request against every stored booking and stores it when it fits.
    function automatic t_verdict judge_booking(input t_time s, input t_time e);
        t_verdict v;
        logic     hit;
        t_time    lo;
        t_time    hi;
        hit = 1'b0;
        for (int k = 0; k < booked_n; k++) begin
            lo = (booked_lo[k] > s) ? booked_lo[k] : s;
            hi = (booked_hi[k] < e) ? booked_hi[k] : e;
            if (lo < hi) hit = 1'b1;
        end
        v = '0;
        if (hit) begin
            v = '0;
        end else if (booked_n >= MAX_BOOKINGS) begin
            v.rejected_full = 1'b1;
        end else begin
            booked_lo[booked_n] = s;
            booked_hi[booked_n] = e;
            booked_n++;
            v.accepted = 1'b1;
        end
        return v;
    endfunction

    function automatic int unsigned draw_pause(input bit quiet);
        return quiet ? 0 : $urandom_range(0, MAX_PAUSE);
    endfunction

    function automatic t_request make_request(input t_time s, input t_time e);
        t_request r;
        r.s = s;
        r.e = e;
        return r;
    endfunction

    // Most requests are short intervals on a coarse grid or variants of earlier
    // requests (copies, partial overlaps, neighbors that just touch), so that
    // once the table is full both overlap and no-overlap cases keep coming.
    function automatic t_request draw_request();
        t_request    r;
        t_request    h;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 35 || asked.size() == 0) begin
            r.s = $urandom_range(0, 199) * 1000 + $urandom_range(0, 800);
            r.e = r.s + $urandom_range(1, 300);
        end else if (pick < 60) begin
            h = asked[$urandom_range(0, asked.size() - 1)];
            case ($urandom_range(0, 3))
                0: r = h;
                1: begin
                    r.s = h.s - $urandom_range(0, 50);
                    r.e = h.s + 1;
                end
                2: begin
                    r.s = h.e;
                    r.e = h.e + $urandom_range(1, 100);
                end
                default: begin
                    r.e = h.s;
                    r.s = h.s - $urandom_range(1, 100);
                end
            endcase
        end else if (pick < 70) begin
            r.s = $urandom();
            r.e = r.s - $urandom_range(0, 3);
        end else if (pick < 85) begin
            r.s = 32'hFFFF_0000 + $urandom_range(0, 65000);
            r.e = r.s + $urandom_range(0, 600);
        end else begin
            r.s = $urandom();
            r.e = $urandom();
        end
        if (r.e > r.s) asked.push_back(r);
        return r;
    endfunction

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Monitor: checks results and records accepted requests.
    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (verdicts_due.size() == 0) begin
                    flag_mismatch("result with no request outstanding");
                end else begin
                    want = verdicts_due.pop_front();
                    if (o_accepted !== want.accepted)
                        flag_mismatch($sformatf("accepted %b, expected %b",
                                                o_accepted, want.accepted));
                    if (o_rejected_full !== want.rejected_full)
                        flag_mismatch($sformatf("rejected_full %b, expected %b",
                                                o_rejected_full, want.rejected_full));
                    if (want.accepted) n_stored++;
                    else if (want.rejected_full) n_full++;
                    else n_overlap++;
                end
                res_taken = 1'b1;
            end
            if (i_valid && o_ready) begin
                verdicts_due.push_back(judge_booking(i_interval_start, i_interval_end));
                req_taken = 1'b1;
            end
        end
    end

    // Driver: presents queued requests with random gaps; idle cycles carry junk.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (req_taken) begin
                req_taken = 1'b0;
                drv_busy = 1'b0;
                drv_sent++;
                if (drv_sent % 100 == 0) drv_quiet = ($urandom_range(0, 2) == 0);
                drv_pause = draw_pause(drv_quiet);
            end
            if (!drv_busy && pending_requests.size() != 0) begin
                if (drv_pause != 0) begin
                    drv_pause--;
                end else begin
                    drv_item = pending_requests.pop_front();
                    drv_busy = 1'b1;
                end
            end
        end
        i_valid <= drv_busy;
        if (drv_busy) begin
            i_interval_start <= drv_item.s;
            i_interval_end <= drv_item.e;
        end else begin
            i_interval_start <= $urandom();
            i_interval_end <= $urandom();
        end
    end

    // Result side: stalls a random number of cycles after each item taken.
    always @(negedge i_clk) begin
        if (res_taken) begin
            res_taken = 1'b0;
            rcv_done++;
            if (rcv_done % 100 == 0) rcv_quiet = ($urandom_range(0, 2) == 0);
            rcv_stall = draw_pause(rcv_quiet);
        end else if (rcv_stall != 0) begin
            rcv_stall--;
        end
        i_ready <= (rcv_stall == 0);
    end

    initial begin
        // Directed: touching neighbors, overlaps, empty intervals, the time
        // extremes, and a wide request that hits every non-empty booking stored so far.
        pending_requests.push_back(make_request(32'd100, 32'd200));
        pending_requests.push_back(make_request(32'd150, 32'd160));
        pending_requests.push_back(make_request(32'd200, 32'd300));
        pending_requests.push_back(make_request(32'd50, 32'd100));
        pending_requests.push_back(make_request(32'd99, 32'd101));
        pending_requests.push_back(make_request(32'd500, 32'd500));
        pending_requests.push_back(make_request(32'd600, 32'd400));
        pending_requests.push_back(make_request(32'd0, 32'd1));
        pending_requests.push_back(make_request(32'hFFFF_FFFE, 32'hFFFF_FFFF));
        pending_requests.push_back(make_request(32'hFFFF_FFFF, 32'hFFFF_FFFF));
        pending_requests.push_back(make_request(32'hFFFF_FFFF, 32'd0));
        pending_requests.push_back(make_request(32'd0, 32'hFFFF_FFFF));
        // Stored empty intervals must not block this one.
        pending_requests.push_back(make_request(32'd400, 32'd600));
        pending_requests.push_back(make_request(32'd1, 32'd2));
        pending_requests.push_back(make_request(32'd0, 32'd2));
        pending_requests.push_back(make_request(32'h5555_5555, 32'hAAAA_AAAA));
        pending_requests.push_back(make_request(32'hAAAA_AAAA, 32'hD555_5555));
        pending_requests.push_back(make_request(32'h5555_5554, 32'h5555_5556));
        // The table fills early in the random part, which then exercises the
        // full table with and without overlap.
        for (int n = 0; n < RANDOM_ITEMS; n++)
            pending_requests.push_back(draw_request());

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_requests.size() != 0 || drv_busy || verdicts_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests in %0d cycles, table full at the end: %0d entries.",
                 drv_sent, cycle_count, booked_n);
        $display("Results: %0d stored, %0d overlapping, %0d turned away by a full table.",
                 n_stored, n_overlap, n_full);
        if (err_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", err_count);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[filelist.f]
src/ibt_pkg.sv
src/ibt_cell.sv
src/ibt_chain.sv
src/interval_booking_table.sv
verif/testbench.sv
